// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is high
`define PCSP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pcsp check failed");

// concurrent check that also holds across reset
`define PCSP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pcsp check failed");

`endif

// ===== src/pcsp_pkg.sv =====
package pcsp_pkg;

   localparam int INSTR_ADDR_W = 48;
   localparam int PHYS_ADDR_W  = 40;
   localparam int PF_ADDR_W    = 40;
   localparam int REQ_DATA_W   = 88;
   localparam int RSP_DATA_W   = 40;

   // remainder unit: bits of instr_addr consumed per cycle
   localparam int DIGIT_BITS   = 4;
   localparam int DIGIT_STEPS  = INSTR_ADDR_W / DIGIT_BITS;
   localparam int STEP_CNT_W   = $clog2(DIGIT_STEPS);

   typedef enum logic [1:0] {
      CONF_STRONG_NT = 2'd0,
      CONF_WEAK_NT   = 2'd1,
      CONF_WEAK_T    = 2'd2,
      CONF_STRONG_T  = 2'd3
   } conf_type;

   typedef enum logic {
      KIND_TRAIN = 1'b0,
      KIND_PEEK  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      IDX_IDLE,
      IDX_RUN,
      IDX_DONE
   } idx_state_type;

endpackage

// ===== src/pc_stride_prefetch_table_unit.sv =====
// PC-indexed stride prefetcher. Each request beat carries a load PC and a
// physical address; the PC modulo ENTRIES selects one table entry holding
// the low bits of the last address, a stride and a 2-bit confidence counter.
// A train beat with a nonzero stride updates the entry and returns a
// prefetch address when the entry is confident and the target stays in the
// same page; a peek beat returns phys_addr plus the stored stride without
// changing the table. Every request gives exactly one response beat. The
// table is a synchronous RAM with a registered read, written back as the
// response is registered, with the last write forwarded; with ENTRIES a
// power of two the index is the PC's low bits and one beat is taken per
// cycle unless the response stalls. Otherwise a remainder unit works 4 PC
// bits a cycle and is busy until its index is handed on. After reset the
// RAM is cleared, one entry a cycle, and req_tready stays low until done.
module pc_stride_prefetch_table_unit
   import pcsp_pkg::*;
#(
   parameter int ENTRIES       = 256,
   parameter int ADDR_LOW_BITS = 16,
   parameter int STRIDE_BITS   = 12,
   parameter int PAGE_BITS     = 12,
   parameter int PADDR_BITS    = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // instr_addr[47:0], phys_addr[87:48]
   input  logic                  req_tuser,   // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // prefetch_addr[39:0]
   output logic                  rsp_tuser    // prefetch_valid
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LOW_W  = (ADDR_LOW_BITS < PADDR_BITS) ? ADDR_LOW_BITS : PADDR_BITS;
   localparam int SW     = (STRIDE_BITS < PADDR_BITS) ? STRIDE_BITS : PADDR_BITS;
   localparam int WORD_W = LOW_W + SW + 2;

   logic                   tbl_ready;
   logic                   ix_in_valid, ix_in_ready;
   logic                   ix_valid, ix_ready;
   kind_type               ix_kind;
   logic [IDX_W-1:0]       ix_idx;
   logic [PHYS_ADDR_W-1:0] ix_pa;
   logic                   load_a, adv_b;

   logic                   s1_valid_ff, s1_valid_in;
   kind_type               s1_kind_ff, s1_kind_in;
   logic [IDX_W-1:0]       s1_idx_ff, s1_idx_in;
   logic [PHYS_ADDR_W-1:0] s1_pa_ff, s1_pa_in;

   logic [WORD_W-1:0]      rd_data, entry;
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0]       fwd_idx_ff, fwd_idx_in;
   logic [WORD_W-1:0]      fwd_data_ff, fwd_data_in;

   logic                   upd_wr;
   logic [LOW_W-1:0]       upd_low;
   logic [SW-1:0]          upd_stride;
   conf_type               upd_conf;
   logic                   upd_pf_valid;
   logic [PF_ADDR_W-1:0]   upd_pf_addr;
   logic                   wr_en;
   logic [WORD_W-1:0]      wr_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_pf_ff, rsp_pf_in;
   logic [PF_ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;

   assign ix_in_valid = req_tvalid & tbl_ready;
   assign req_tready  = ix_in_ready & tbl_ready;

   pcsp_index #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_index (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (ix_in_valid),
      .in_ready      (ix_in_ready),
      .in_kind       (kind_type'(req_tuser)),
      .in_instr_addr (req_tdata[INSTR_ADDR_W-1:0]),
      .in_phys_addr  (req_tdata[REQ_DATA_W-1:INSTR_ADDR_W]),
      .out_valid     (ix_valid),
      .out_ready     (ix_ready),
      .out_kind      (ix_kind),
      .out_idx       (ix_idx),
      .out_phys_addr (ix_pa)
   );

   assign adv_b    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign ix_ready = tbl_ready & (~s1_valid_ff | adv_b);
   assign load_a   = ix_valid & ix_ready;

   pcsp_table #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W),
      .WORD_W  (WORD_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .ready   (tbl_ready),
      .rd_en   (load_a),
      .rd_idx  (ix_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_idx  (s1_idx_ff),
      .wr_data (wr_data)
   );

   // entry word: {conf, stride, last_low}
   assign entry = (fwd_valid_ff && fwd_idx_ff == s1_idx_ff) ? fwd_data_ff : rd_data;

   pcsp_update #(
      .PW        (PADDR_BITS),
      .LOW_W     (LOW_W),
      .SW        (SW),
      .PAGE_BITS (PAGE_BITS)
   ) u_update (
      .kind         (s1_kind_ff),
      .phys_addr    (s1_pa_ff),
      .last_low     (entry[LOW_W-1:0]),
      .stride_old   (entry[LOW_W+SW-1:LOW_W]),
      .conf_old     (conf_type'(entry[WORD_W-1:LOW_W+SW])),
      .wr_en        (upd_wr),
      .last_low_new (upd_low),
      .stride_new   (upd_stride),
      .conf_new     (upd_conf),
      .pf_valid     (upd_pf_valid),
      .pf_addr      (upd_pf_addr)
   );

   assign wr_en   = adv_b & upd_wr;
   assign wr_data = {upd_conf, upd_stride, upd_low};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_idx_in   = s1_idx_ff;
      s1_pa_in    = s1_pa_ff;
      if (load_a) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = ix_kind;
         s1_idx_in   = ix_idx;
         s1_pa_in    = ix_pa;
      end else if (adv_b) begin
         s1_valid_in = 1'b0;
      end

      fwd_valid_in = fwd_valid_ff | wr_en;
      fwd_idx_in   = wr_en ? s1_idx_ff : fwd_idx_ff;
      fwd_data_in  = wr_en ? wr_data : fwd_data_ff;

      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_pf_in    = rsp_pf_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (adv_b) begin
         rsp_valid_in = 1'b1;
         rsp_pf_in    = upd_pf_valid;
         rsp_addr_in  = upd_pf_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_kind_ff  <= s1_kind_in;
      s1_idx_ff   <= s1_idx_in;
      s1_pa_ff    <= s1_pa_in;
      fwd_idx_ff  <= fwd_idx_in;
      fwd_data_ff <= fwd_data_in;
      rsp_pf_ff   <= rsp_pf_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_pf_ff;

endmodule

// ===== src/pcsp_index.sv =====
module pcsp_index
   import pcsp_pkg::*;
#(
   parameter int ENTRIES = 256,
   parameter int IDX_W   = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  kind_type                in_kind,
   input  logic [INSTR_ADDR_W-1:0] in_instr_addr,
   input  logic [PHYS_ADDR_W-1:0]  in_phys_addr,
   output logic                    out_valid,
   input  logic                    out_ready,
   output kind_type                out_kind,
   output logic [IDX_W-1:0]        out_idx,
   output logic [PHYS_ADDR_W-1:0]  out_phys_addr
);

   localparam bit IS_POW2 = (ENTRIES & (ENTRIES - 1)) == 0;

   if (IS_POW2) begin : g_mask
      assign in_ready      = out_ready;
      assign out_valid     = in_valid;
      assign out_kind      = in_kind;
      assign out_phys_addr = in_phys_addr;
      assign out_idx       = IDX_W'(in_instr_addr) & IDX_W'(ENTRIES - 1);
   end else begin : g_rem
      localparam logic [IDX_W:0] ENT = (IDX_W + 1)'(ENTRIES);

      idx_state_type                 state_ff, state_in;
      logic [INSTR_ADDR_W-1:0]       val_ff, val_in;
      logic [IDX_W-1:0]              rem_ff, rem_in;
      logic [STEP_CNT_W-1:0]         cnt_ff, cnt_in;
      kind_type                      kind_ff, kind_in;
      logic [PHYS_ADDR_W-1:0]        pa_ff, pa_in;
      logic [IDX_W:0]                part;
      logic [IDX_W-1:0]              rem_step;

      // one digit of restoring remainder
      always_comb begin
         rem_step = rem_ff;
         for (int j = 0; j < DIGIT_BITS; j++) begin
            part = {rem_step, val_ff[INSTR_ADDR_W-1-j]};
            if (part >= ENT) begin
               part = part - ENT;
            end
            rem_step = part[IDX_W-1:0];
         end
      end

      always_comb begin
         state_in = state_ff;
         case (state_ff)
            IDX_IDLE: if (in_valid) state_in = IDX_RUN;
            IDX_RUN:  if (cnt_ff == STEP_CNT_W'(DIGIT_STEPS - 1)) state_in = IDX_DONE;
            IDX_DONE: if (out_ready) state_in = IDX_IDLE;
            default:  state_in = IDX_IDLE;
         endcase
      end

      always_comb begin
         in_ready  = 1'b0;
         out_valid = 1'b0;
         val_in    = val_ff;
         rem_in    = rem_ff;
         cnt_in    = cnt_ff;
         kind_in   = kind_ff;
         pa_in     = pa_ff;
         case (state_ff)
            IDX_IDLE: begin
               in_ready = 1'b1;
               val_in   = in_instr_addr;
               rem_in   = '0;
               cnt_in   = '0;
               kind_in  = in_kind;
               pa_in    = in_phys_addr;
            end
            IDX_RUN: begin
               val_in = val_ff << DIGIT_BITS;
               rem_in = rem_step;
               cnt_in = cnt_ff + 1'b1;
            end
            IDX_DONE: begin
               out_valid = 1'b1;
            end
            default: ;
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            state_ff <= IDX_IDLE;
         end else begin
            state_ff <= state_in;
         end
         val_ff  <= val_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
         kind_ff <= kind_in;
         pa_ff   <= pa_in;
      end

      assign out_kind      = kind_ff;
      assign out_idx       = rem_ff;
      assign out_phys_addr = pa_ff;
   end

endmodule

// ===== src/pcsp_table.sv =====
module pcsp_table #(
   parameter int ENTRIES = 256,
   parameter int IDX_W   = 8,
   parameter int WORD_W  = 30
) (
   input  logic              clock,
   input  logic              reset,
   output logic              ready,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [WORD_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [WORD_W-1:0] wr_data
);

   logic [WORD_W-1:0] mem_ff [ENTRIES];
   logic [WORD_W-1:0] rd_data_ff;
   logic              clearing_ff, clearing_in;
   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;
   logic              wr_sel;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_word;

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == IDX_W'(ENTRIES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   assign wr_sel  = clearing_ff | wr_en;
   assign wr_addr = clearing_ff ? clr_idx_ff : wr_idx;
   assign wr_word = clearing_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         mem_ff[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   assign ready   = ~clearing_ff;
   assign rd_data = rd_data_ff;

endmodule

// ===== src/pcsp_update.sv =====
module pcsp_update
   import pcsp_pkg::*;
#(
   parameter int PW        = 40,
   parameter int LOW_W     = 16,
   parameter int SW        = 12,
   parameter int PAGE_BITS = 12
) (
   input  kind_type               kind,
   input  logic [PHYS_ADDR_W-1:0] phys_addr,
   input  logic [LOW_W-1:0]       last_low,
   input  logic [SW-1:0]          stride_old,
   input  conf_type               conf_old,
   output logic                   wr_en,
   output logic [LOW_W-1:0]       last_low_new,
   output logic [SW-1:0]          stride_new,
   output conf_type               conf_new,
   output logic                   pf_valid,
   output logic [PF_ADDR_W-1:0]   pf_addr
);

   localparam logic [PW-1:0] LOW_MASK = {PW{1'b1}} >> (PW - LOW_W);

   logic [PW-1:0] pa;
   logic [PW-1:0] last_full;
   logic [PW-1:0] diff;
   logic [SW-1:0] stride;
   logic          correct;
   logic [PW-1:0] cand;
   logic [PW-1:0] peek_addr;
   logic          same_page;

   always_comb begin
      pa           = PW'(phys_addr);
      last_full    = (pa & ~LOW_MASK) | PW'(last_low);
      diff         = pa - last_full;
      stride       = diff[SW-1:0];
      last_low_new = pa[LOW_W-1:0];
      stride_new   = (conf_old != CONF_STRONG_T) ? stride : stride_old;
      correct      = (stride == stride_new);

      case (conf_old)
         CONF_STRONG_NT: conf_new = correct ? CONF_WEAK_NT  : CONF_STRONG_NT;
         CONF_WEAK_NT:   conf_new = correct ? CONF_STRONG_T : CONF_STRONG_NT;
         CONF_WEAK_T:    conf_new = correct ? CONF_STRONG_T : CONF_WEAK_NT;
         CONF_STRONG_T:  conf_new = correct ? CONF_STRONG_T : CONF_WEAK_T;
         default:        conf_new = CONF_STRONG_NT;
      endcase

      cand      = pa + PW'(stride_new);
      peek_addr = pa + PW'(stride_old);
      same_page = (cand >> PAGE_BITS) == (pa >> PAGE_BITS);

      wr_en    = 1'b0;
      pf_valid = 1'b0;
      pf_addr  = '0;
      if (kind == KIND_PEEK) begin
         pf_valid = 1'b1;
         pf_addr  = PF_ADDR_W'(peek_addr);
      end else if (stride != '0) begin
         wr_en = 1'b1;
         if (conf_new != CONF_STRONG_NT && same_page) begin
            pf_valid = 1'b1;
            pf_addr  = PF_ADDR_W'(cand);
         end
      end
   end

endmodule

// ===== src/pcsp_checker.sv =====
`include "assert_macros.svh"

module pcsp_checker
   import pcsp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic [2:0] pend_ff, pend_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_tvalid & req_tready;
   assign rsp_beat = rsp_tvalid & rsp_tready;

   always_comb begin
      pend_in = pend_ff + {2'b00, req_beat} - {2'b00, rsp_beat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `PCSP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `PCSP_ASSERT(a_no_pf_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
   `PCSP_ASSERT(a_rsp_has_req, clock, reset, rsp_tvalid |-> pend_ff != 3'd0)
   `PCSP_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid && !req_tready)

endmodule

bind pc_stride_prefetch_table_unit pcsp_checker u_pcsp_checker (.*);
